>>> design/tfrcpu_pkg.sv
package tfrcpu_pkg;

   localparam int REG_WIDTH   = 8;
   localparam int NUM_REGS    = 4;
   localparam int REG_ADDR_W  = $clog2(NUM_REGS);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int DIV_STEPS   = REG_WIDTH;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

   localparam logic [7:0] ARITH_BASE = 8'h80;
   localparam logic [7:0] IO_BASE    = 8'hC0;
   localparam logic [5:0] OP_IN      = 6'h30;
   localparam logic [5:0] OP_OUT     = 6'h31;
   localparam logic [REG_ADDR_W-1:0] REG_D = REG_ADDR_W'(3);

   typedef enum logic [2:0] {
      KIND_MOV,
      KIND_ARITH,
      KIND_IN,
      KIND_OUT,
      KIND_ILLEGAL
   } kind_type;

   typedef enum logic [1:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_MUL,
      ALU_DIV
   } alu_op_type;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_DIV0,
      STATUS_ILLEGAL
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIV
   } back_state_type;

   typedef struct packed {
      kind_type                kind;
      alu_op_type              alu_op;
      logic [REG_ADDR_W-1:0]   dst;
      logic [REG_ADDR_W-1:0]   src;
      logic [REG_WIDTH-1:0]    value;
   } uop_type;

   typedef struct packed {
      logic                    start;
      logic [REG_WIDTH-1:0]    dividend;
      logic [REG_WIDTH-1:0]    divisor;
   } div_req_type;

   typedef struct packed {
      logic                    done;
      logic [REG_WIDTH-1:0]    quotient;
   } div_rsp_type;

endpackage

>>> design/tfrcpu_if.sv
interface tfrcpu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] instruction;
   logic [7:0] in_value;

   modport source (output valid, output instruction, output in_value, input ready);
   modport sink (input valid, input instruction, input in_value, output ready);
endinterface

interface tfrcpu_rsp_if;
   logic       valid;
   logic       ready;
   logic       out_valid;
   logic [7:0] out_value;
   logic [1:0] status;

   modport source (output valid, output out_valid, output out_value, output status,
                   input ready);
   modport sink (input valid, input out_valid, input out_value, input status,
                 output ready);
endinterface

>>> design/tfrcpu_ram.sv
module tfrcpu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a_ff <= mem[rd_addr_a];
         rd_data_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

>>> design/tfrcpu_front.sv
module tfrcpu_front (
   input  logic                clock,
   input  logic                reset,
   tfrcpu_req_if.sink          req_bus,
   output tfrcpu_pkg::uop_type q_uop,
   output logic                q_valid,
   input  logic                q_pop
);

   tfrcpu_pkg::uop_type                      dec_uop;
   tfrcpu_pkg::uop_type                      entry_ff [tfrcpu_pkg::QUEUE_DEPTH];
   logic [tfrcpu_pkg::QPTR_W-1:0]            wr_ptr_ff, wr_ptr_in;
   logic [tfrcpu_pkg::QPTR_W-1:0]            rd_ptr_ff, rd_ptr_in;
   logic [tfrcpu_pkg::QCNT_W-1:0]            count_ff, count_in;
   logic                                     push;
   logic [7:0]                               instr;

   assign instr = req_bus.instruction;

   always_comb begin
      dec_uop.alu_op = tfrcpu_pkg::alu_op_type'(instr[5:4]);
      dec_uop.dst    = instr[3:2];
      dec_uop.src    = instr[1:0];
      dec_uop.value  = req_bus.in_value;
      if (instr < tfrcpu_pkg::ARITH_BASE) begin
         dec_uop.kind  = tfrcpu_pkg::KIND_MOV;
         dec_uop.value = instr;
      end else if (instr < tfrcpu_pkg::IO_BASE) begin
         dec_uop.kind = tfrcpu_pkg::KIND_ARITH;
      end else if (instr[7:2] == tfrcpu_pkg::OP_IN) begin
         dec_uop.kind = tfrcpu_pkg::KIND_IN;
      end else if (instr[7:2] == tfrcpu_pkg::OP_OUT) begin
         dec_uop.kind = tfrcpu_pkg::KIND_OUT;
      end else begin
         dec_uop.kind = tfrcpu_pkg::KIND_ILLEGAL;
      end
   end

   assign req_bus.ready = (count_ff != tfrcpu_pkg::QCNT_W'(tfrcpu_pkg::QUEUE_DEPTH));
   assign push          = req_bus.valid && req_bus.ready;
   assign q_valid       = (count_ff != '0);
   assign q_uop         = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == tfrcpu_pkg::QPTR_W'(tfrcpu_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == tfrcpu_pkg::QPTR_W'(tfrcpu_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, q_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= dec_uop;
      end
   end

endmodule

>>> design/tfrcpu_div.sv
module tfrcpu_div (
   input  logic                    clock,
   input  logic                    reset,
   input  tfrcpu_pkg::div_req_type req,
   output tfrcpu_pkg::div_rsp_type rsp
);

   logic                                 busy_ff, busy_in;
   logic                                 done_ff, done_in;
   logic [tfrcpu_pkg::DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [tfrcpu_pkg::REG_WIDTH-1:0]     rem_ff, rem_in;
   logic [tfrcpu_pkg::REG_WIDTH-1:0]     quo_ff, quo_in;
   logic [tfrcpu_pkg::REG_WIDTH-1:0]     dsr_ff, dsr_in;
   logic [tfrcpu_pkg::REG_WIDTH:0]       shifted;
   logic [tfrcpu_pkg::REG_WIDTH:0]       trial;

   assign shifted = {rem_ff, quo_ff[tfrcpu_pkg::REG_WIDTH-1]};
   assign trial   = shifted - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (req.start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = req.dividend;
         dsr_in  = req.divisor;
      end else if (busy_ff) begin
         if (!trial[tfrcpu_pkg::REG_WIDTH]) begin
            rem_in = trial[tfrcpu_pkg::REG_WIDTH-1:0];
         end else begin
            rem_in = shifted[tfrcpu_pkg::REG_WIDTH-1:0];
         end
         quo_in = {quo_ff[tfrcpu_pkg::REG_WIDTH-2:0], ~trial[tfrcpu_pkg::REG_WIDTH]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == tfrcpu_pkg::DIV_CNT_W'(tfrcpu_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

>>> design/tfrcpu_back.sv
module tfrcpu_back (
   input  logic                clock,
   input  logic                reset,
   input  tfrcpu_pkg::uop_type q_uop,
   input  logic                q_valid,
   output logic                q_pop,
   tfrcpu_rsp_if.source        rsp_bus
);

   localparam int W  = tfrcpu_pkg::REG_WIDTH;
   localparam int AW = tfrcpu_pkg::REG_ADDR_W;

   tfrcpu_pkg::back_state_type state_ff, state_in;
   tfrcpu_pkg::uop_type        uop_ff, uop_in;
   tfrcpu_pkg::div_req_type    div_req;
   tfrcpu_pkg::div_rsp_type    div_rsp;
   tfrcpu_pkg::status_type     status_ff, status_in;
   logic [tfrcpu_pkg::NUM_REGS-1:0] written_ff, written_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       out_valid_ff, out_valid_in;
   logic [W-1:0]               out_value_ff, out_value_in;
   logic                       wr_en;
   logic [AW-1:0]              wr_addr;
   logic [W-1:0]               wr_data;
   logic                       rd_en;
   logic [W-1:0]               rd_a, rd_b;
   logic [W-1:0]               a_val, b_val;
   logic [2*W-1:0]             product;
   logic                       slot_free;

   tfrcpu_ram #(
      .WIDTH (W),
      .DEPTH (tfrcpu_pkg::NUM_REGS)
   ) u_regs (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr_a (q_uop.dst),
      .rd_addr_b (q_uop.src),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   tfrcpu_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign a_val     = written_ff[uop_ff.dst] ? rd_a : '0;
   assign b_val     = written_ff[uop_ff.src] ? rd_b : '0;
   assign product   = a_val * b_val;
   assign slot_free = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      state_in         = state_ff;
      uop_in           = uop_ff;
      status_in        = status_ff;
      written_in       = written_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_bus.ready;
      out_valid_in     = out_valid_ff;
      out_value_in     = out_value_ff;
      wr_en            = 1'b0;
      wr_addr          = uop_ff.dst;
      wr_data          = a_val;
      rd_en            = 1'b0;
      q_pop            = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = a_val;
      div_req.divisor  = b_val;

      unique case (state_ff)
         tfrcpu_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               rd_en    = 1'b1;
               uop_in   = q_uop;
               state_in = tfrcpu_pkg::ST_EXEC;
            end
         end
         tfrcpu_pkg::ST_EXEC: begin
            if (uop_ff.kind == tfrcpu_pkg::KIND_ARITH && uop_ff.alu_op == tfrcpu_pkg::ALU_DIV
                && b_val != '0) begin
               div_req.start = 1'b1;
               state_in      = tfrcpu_pkg::ST_DIV;
            end else if (slot_free) begin
               rsp_valid_in = 1'b1;
               out_valid_in = 1'b0;
               out_value_in = '0;
               status_in    = tfrcpu_pkg::STATUS_OK;
               state_in     = tfrcpu_pkg::ST_IDLE;
               unique case (uop_ff.kind)
                  tfrcpu_pkg::KIND_MOV: begin
                     wr_en   = 1'b1;
                     wr_addr = tfrcpu_pkg::REG_D;
                     wr_data = uop_ff.value;
                  end
                  tfrcpu_pkg::KIND_IN: begin
                     wr_en   = 1'b1;
                     wr_addr = uop_ff.src;
                     wr_data = uop_ff.value;
                  end
                  tfrcpu_pkg::KIND_OUT: begin
                     out_valid_in = 1'b1;
                     out_value_in = b_val;
                  end
                  tfrcpu_pkg::KIND_ARITH: begin
                     unique case (uop_ff.alu_op)
                        tfrcpu_pkg::ALU_ADD: begin
                           wr_en   = 1'b1;
                           wr_data = a_val + b_val;
                        end
                        tfrcpu_pkg::ALU_SUB: begin
                           wr_en   = 1'b1;
                           wr_data = a_val - b_val;
                        end
                        tfrcpu_pkg::ALU_MUL: begin
                           wr_en   = 1'b1;
                           wr_data = product[W-1:0];
                        end
                        tfrcpu_pkg::ALU_DIV: begin
                           status_in = tfrcpu_pkg::STATUS_DIV0;
                        end
                        default: begin
                           status_in = tfrcpu_pkg::STATUS_OK;
                        end
                     endcase
                  end
                  default: begin
                     status_in = tfrcpu_pkg::STATUS_ILLEGAL;
                  end
               endcase
            end
         end
         tfrcpu_pkg::ST_DIV: begin
            if (div_rsp.done && slot_free) begin
               wr_en        = 1'b1;
               wr_data      = div_rsp.quotient;
               rsp_valid_in = 1'b1;
               out_valid_in = 1'b0;
               out_value_in = '0;
               status_in    = tfrcpu_pkg::STATUS_OK;
               state_in     = tfrcpu_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tfrcpu_pkg::ST_IDLE;
         end
      endcase

      if (wr_en) begin
         written_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tfrcpu_pkg::ST_IDLE;
         written_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         written_ff   <= written_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      uop_ff       <= uop_in;
      status_ff    <= status_in;
      out_valid_ff <= out_valid_in;
      out_value_ff <= out_value_in;
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.out_valid = out_valid_ff;
   assign rsp_bus.out_value = out_value_ff;
   assign rsp_bus.status    = status_ff;

endmodule

>>> design/tiny_four_register_cpu_execute_top.sv
// Executes one 8-bit instruction per req_bus beat on four 8-bit registers (A, B, C, D),
// all zero after reset, and returns exactly one rsp_bus beat per instruction with
// out_valid, out_value and status (0 ok, 1 divide by zero, 2 illegal). A two-entry
// decode queue sits in front of the execute unit, so up to two instructions are taken
// while the execute unit is busy or a result waits. Instructions run one at a time:
// move, add, subtract, multiply, in, out and illegal go through register read, then
// execute and write back; divide goes through register read, start, eight steps of the
// restoring divider and write back; divide by zero takes register read, then execute.
module tiny_four_register_cpu_execute_top (
   input  logic          clock,
   input  logic          reset,
   tfrcpu_req_if.sink    req_bus,
   tfrcpu_rsp_if.source  rsp_bus
);

   tfrcpu_pkg::uop_type q_uop;
   logic                q_valid;
   logic                q_pop;

   tfrcpu_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .q_uop   (q_uop),
      .q_valid (q_valid),
      .q_pop   (q_pop)
   );

   tfrcpu_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_uop   (q_uop),
      .q_valid (q_valid),
      .q_pop   (q_pop),
      .rsp_bus (rsp_bus)
   );

endmodule

>>> tb/sv/tfrcpu_exec_checker.sv
module tfrcpu_exec_checker
   import tfrcpu_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   tfrcpu_req_if  req_bus,
   tfrcpu_rsp_if  rsp_bus,
   output int     mismatch_count,
   output int     outstanding
);

   typedef struct packed {
      logic                 out_valid;
      logic [REG_WIDTH-1:0] out_value;
      status_type           status;
   } exec_result_t;

   logic [REG_WIDTH-1:0] shadow_regs [NUM_REGS];
   exec_result_t         pending_results [$];
   int                   errors = 0;

   function automatic exec_result_t execute_instruction(input logic [7:0] instr,
                                                        input logic [7:0] value);
      exec_result_t          r;
      logic [REG_ADDR_W-1:0] src;
      logic [REG_ADDR_W-1:0] dst;
      logic [REG_WIDTH-1:0]  a;
      logic [REG_WIDTH-1:0]  b;
      r   = '{1'b0, '0, STATUS_OK};
      src = instr[1:0];
      dst = instr[3:2];
      a   = shadow_regs[dst];
      b   = shadow_regs[src];
      if (instr < ARITH_BASE) begin
         shadow_regs[REG_D] = instr;
      end else if (instr < IO_BASE) begin
         case (alu_op_type'(instr[5:4]))
            ALU_ADD: begin
               shadow_regs[dst] = a + b;
            end
            ALU_SUB: begin
               shadow_regs[dst] = a - b;
            end
            ALU_MUL: begin
               shadow_regs[dst] = a * b;
            end
            default: begin
               if (b == '0) r.status = STATUS_DIV0;
               else shadow_regs[dst] = a / b;
            end
         endcase
      end else if (instr[7:2] == OP_IN) begin
         shadow_regs[src] = value;
      end else if (instr[7:2] == OP_OUT) begin
         r.out_valid = 1'b1;
         r.out_value = b;
      end else begin
         r.status = STATUS_ILLEGAL;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      exec_result_t want;
      if (reset) begin
         foreach (shadow_regs[i]) shadow_regs[i] = '0;
         pending_results.delete();
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_results.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: result beat with none expected: out_valid=%0b out_value=%02h status=%0d",
                           $realtime, rsp_bus.out_valid, rsp_bus.out_value, rsp_bus.status);
            end else begin
               want = pending_results.pop_front();
               if (rsp_bus.out_valid !== want.out_valid || rsp_bus.out_value !== want.out_value ||
                   rsp_bus.status !== want.status) begin
                  errors++;
                  if (errors <= 10)
                     $display("%0t: mismatch: expected out_valid=%0b out_value=%02h status=%0d, got out_valid=%0b out_value=%02h status=%0d",
                              $realtime, want.out_valid, want.out_value, want.status,
                              rsp_bus.out_valid, rsp_bus.out_value, rsp_bus.status);
               end
            end
         end
         if (req_bus.valid && req_bus.ready)
            pending_results.push_back(execute_instruction(req_bus.instruction, req_bus.in_value));
      end
      mismatch_count <= errors;
      outstanding    <= pending_results.size();
   end

endmodule

>>> tb/sv/tb.sv
module tb;
   import tfrcpu_pkg::*;

   localparam int STALL_LIMIT  = 4000;
   localparam int RANDOM_BEATS = 450;

   logic clock;
   logic reset;
   logic steady;
   int   mismatch_count;
   int   outstanding;

   tfrcpu_req_if req_bus ();
   tfrcpu_rsp_if rsp_bus ();

   tiny_four_register_cpu_execute_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   tfrcpu_exec_checker chk (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   task automatic send_beat(input logic [7:0] instr, input logic [7:0] value);
      while (!steady && $urandom_range(99) < 28) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.instruction <= instr;
      req_bus.in_value    <= value;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   function automatic logic [7:0] random_instruction();
      int pick;
      pick = $urandom_range(99);
      if (pick < 12) return {1'b0, 7'($urandom)};
      else if (pick < 52) return {2'b10, 6'($urandom)};
      else if (pick < 70) return {OP_IN, 2'($urandom)};
      else if (pick < 88) return {OP_OUT, 2'($urandom)};
      else if (pick < 94) return 8'($urandom_range(8'hFF, 8'hC8));
      else return 8'($urandom);
   endfunction

   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= steady ? 1'b1 : ($urandom_range(99) >= 28);
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      @(negedge reset);
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) quiet = 0;
         else quiet++;
      end
      $display("FAIL tiny_four_register_cpu_execute_top");
      $finish;
   end

   initial begin
      logic [7:0] directed_instr [$];
      logic [7:0] directed_value [$];
      steady              = 1'b0;
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.instruction <= '0;
      req_bus.in_value    <= '0;
      directed_instr = '{8'hC4, 8'h00, 8'h7F, 8'hC0, 8'hC1, 8'hC2, 8'hB1, 8'h80, 8'h94,
                         8'hAA, 8'hC2, 8'hA8, 8'hBF, 8'hB1, 8'hC4, 8'hC5, 8'hC6, 8'hC7,
                         8'hC8, 8'hFF, 8'hC3, 8'h90, 8'hBC, 8'hC4, 8'hC7};
      directed_value = '{8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h80, 8'h00, 8'hFF, 8'h00,
                         8'hFF, 8'h10, 8'h00, 8'hAA, 8'h55, 8'h00, 8'hFF, 8'h00, 8'hFF,
                         8'hFF, 8'h00, 8'h55, 8'hFF, 8'h00, 8'hFF, 8'h00};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_instr[i]) send_beat(directed_instr[i], directed_value[i]);
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         steady = (n >= 150 && n < 260);
         if (n == 320) begin
            req_bus.valid <= 1'b0;
            do @(posedge clock); while (outstanding != 0);
         end
         send_beat(random_instruction(), 8'($urandom));
      end
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) $display("PASS tiny_four_register_cpu_execute_top");
      else $display("FAIL tiny_four_register_cpu_execute_top");
      $finish;
   end

endmodule
